// File: rtl/kdlpr_pkg.sv
// types and helper functions for the key debounce / long press / repeat block
// no dependencies
package kdlpr_pkg;

    localparam int unsigned NUM_KEYS = 8;
    localparam logic [7:0]  ALL_UP   = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HELD    = 2'd2,
        PH_SECOND  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        SK_NONE   = 2'd0,
        SK_REPEAT = 2'd1,
        SK_LONG   = 2'd2
    } second_t;

    typedef enum logic [1:0] {
        REG_REPEAT_MASK   = 2'd0,
        REG_LONG_MASK     = 2'd1,
        REG_TRIGGER_TICKS = 2'd2,
        REG_REPEAT_TICKS  = 2'd3
    } reg_idx_t;

    // repeat has priority over long press
    function automatic second_t second_kind(input logic [7:0] mask,
                                            input logic [7:0] rep_mask,
                                            input logic [7:0] lng_mask);
        second_t k;
        if ((mask & rep_mask) != 8'd0)
            k = SK_REPEAT;
        else if ((mask & lng_mask) != 8'd0)
            k = SK_LONG;
        else
            k = SK_NONE;
        return k;
    endfunction

    // key number 1..8 of a one-hot mask, 0 when nothing is set
    function automatic logic [3:0] key_number(input logic [7:0] down);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (down[k])
                n = 4'(k + 1);
        end
        return n;
    endfunction

endpackage

// File: rtl/key_debounce_long_press_repeat.sv
// key debounce with long press and auto-repeat: top level
// depends on kdlpr_pkg
//
// channel   dir  handshake                fields
// -------   ---  ---------                ------
// sample    in   key_valid / key_ready    key_pins[7:0]
// code      out  code_valid / code_ready  key_code[4:0]
// config    in   apb psel/penable/pwrite  paddr[3:0], pwdata/prdata[31:0]
//
// one sample per cycle sustained while code_ready is high; an accepted sample sits
// in the input register, and the phase machine steps on it when the input register
// drains and registers any code in the output register, which drives code_valid
// a code waiting at the output stalls the phase machine; the input register takes
// one more sample, then key_ready stays low until code_ready
// reset clears phase, key, mask, counter and the registers to their defaults
module key_debounce_long_press_repeat (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_ready,
    input  logic [7:0]  key_pins,
    output logic        code_valid,
    input  logic        code_ready,
    output logic [4:0]  key_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kdlpr_pkg::*;

    logic [7:0] repeat_mask_reg;
    logic [7:0] long_mask_reg;
    logic [7:0] trigger_ticks_reg;
    logic [7:0] repeat_ticks_reg;

    logic       s1_valid_reg;
    logic [7:0] pins_reg;

    phase_t     phase_reg,      phase_next;
    logic [3:0] held_key_reg,   held_key_next;
    logic [7:0] held_mask_reg,  held_mask_next;
    logic [7:0] tick_count_reg, tick_count_next;

    logic       out_valid_reg,  out_valid_next;
    logic [4:0] out_code_reg,   out_code_next;

    logic       fire;
    logic       released;
    logic [7:0] down;
    second_t    kind;
    reg_idx_t   widx;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_mask_reg   <= 8'd0;
            long_mask_reg     <= 8'd0;
            trigger_ticks_reg <= 8'd100;
            repeat_ticks_reg  <= 8'd10;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (widx)
                REG_REPEAT_MASK:   repeat_mask_reg   <= pwdata[7:0];
                REG_LONG_MASK:     long_mask_reg     <= pwdata[7:0];
                REG_TRIGGER_TICKS: trigger_ticks_reg <= pwdata[7:0];
                REG_REPEAT_TICKS:  repeat_ticks_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_REPEAT_MASK:   prdata = {24'd0, repeat_mask_reg};
            REG_LONG_MASK:     prdata = {24'd0, long_mask_reg};
            REG_TRIGGER_TICKS: prdata = {24'd0, trigger_ticks_reg};
            REG_REPEAT_TICKS:  prdata = {24'd0, repeat_ticks_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // the input register drains whenever the output register is free or being taken
    assign fire      = s1_valid_reg && (!out_valid_reg || code_ready);
    assign key_ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (key_ready)
            s1_valid_reg <= key_valid;
    end

    always_ff @(posedge clk)
    begin
        if (key_ready && key_valid)
            pins_reg <= key_pins;
    end

    assign released = (pins_reg == ALL_UP);
    assign down     = ~pins_reg;
    assign kind     = second_kind(held_mask_reg, repeat_mask_reg, long_mask_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        held_key_next   = held_key_reg;
        held_mask_next  = held_mask_reg;
        tick_count_next = tick_count_reg;
        out_valid_next  = out_valid_reg && !code_ready;
        out_code_next   = out_code_reg;
        if (fire)
        begin
            out_valid_next = 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!released)
                    begin
                        phase_next      = PH_CONFIRM;
                        tick_count_next = 8'd0;
                    end
                end
                PH_CONFIRM:
                begin
                    if (!released)
                    begin
                        // a chord keeps the previous key
                        if ($onehot(down))
                        begin
                            held_key_next  = key_number(down);
                            held_mask_next = down;
                        end
                        phase_next = PH_HELD;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                PH_HELD:
                begin
                    if (released)
                    begin
                        phase_next      = PH_IDLE;
                        tick_count_next = 8'd0;
                        out_valid_next  = 1'b1;
                        out_code_next   = {1'b0, held_key_reg};
                    end
                    else if (kind != SK_NONE)
                    begin
                        if (tick_count_reg < trigger_ticks_reg)
                            tick_count_next = tick_count_reg + 8'd1;
                        else
                        begin
                            tick_count_next = 8'd0;
                            phase_next      = PH_SECOND;
                        end
                    end
                end
                PH_SECOND:
                begin
                    if (released)
                    begin
                        phase_next      = PH_IDLE;
                        tick_count_next = 8'd0;
                    end
                    else if (kind == SK_REPEAT)
                    begin
                        if (tick_count_reg < repeat_ticks_reg)
                            tick_count_next = tick_count_reg + 8'd1;
                        else
                        begin
                            tick_count_next = 8'd0;
                            out_valid_next  = 1'b1;
                            out_code_next   = {1'b0, held_key_reg};
                        end
                    end
                    else if (tick_count_reg == 8'd0)
                    begin
                        // long code once: key plus sixteen
                        out_valid_next  = 1'b1;
                        out_code_next   = {1'b1, held_key_reg};
                        tick_count_next = 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_key_reg   <= 4'd0;
            held_mask_reg  <= 8'd0;
            tick_count_reg <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_key_reg   <= held_key_next;
            held_mask_reg  <= held_mask_next;
            tick_count_reg <= tick_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg <= out_code_next;
    end

    assign code_valid = out_valid_reg;
    assign key_code   = out_code_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !fire |=> s1_valid_reg && $stable(pins_reg))
        else $error("input register lost a waiting sample");

    a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(held_mask_reg))
        else $error("held mask has more than one key");

    a_idle_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_IDLE |=> !out_valid_reg)
        else $error("code produced from idle phase");

    a_key_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        held_mask_reg != 8'd0 |-> held_key_reg == key_number(held_mask_reg))
        else $error("held key and held mask disagree");

endmodule
